>>> hdl/tlpq_pkg.sv
// shared types, constants and helper functions for the three-level priority queue
package tlpq_pkg;

	localparam int LEVEL_DEPTH = 16;
	localparam int VALUE_BITS = 32;
	localparam int NUM_LEVELS = 3;

	localparam int IDX_W = $clog2(LEVEL_DEPTH);
	localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
	localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);
	localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic signed [VALUE_BITS-1:0] word_t;
	typedef logic [1:0] lvl_t;

	// level index 0..2, this code when every level is empty
	localparam lvl_t LVL_NONE = 2'd3;
	localparam logic [1:0] PRI_NONE = 2'd0;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
		logic [1:0]         priority_req;
	} item_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		word_t wdata;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0] front_priority;
		logic [4:0] high_count;
		logic [4:0] medium_count;
		logic [4:0] low_count;
		logic       is_empty;
		status_t    status;
		logic       bypass;
		word_t      bypass_value;
	} result_t;

	function automatic idx_t ring_next(input idx_t i);
		return (i == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// first non-empty level, high priority first
	function automatic lvl_t top_level(input logic [NUM_LEVELS-1:0] nonempty);
		lvl_t lv;
		lv = LVL_NONE;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (nonempty[l]) begin
				lv = lvl_t'(l);
			end
		end
		return lv;
	endfunction

	function automatic addr_t addr_of(input lvl_t lv, input idx_t i);
		return ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(i);
	endfunction

endpackage

>>> hdl/tlpq_ifs.sv
// request and response channel interfaces for the three-level priority queue
interface tlpq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] value;
	logic [1:0]         priority_req;

	modport source (output valid, output operation, output value, output priority_req,
		input ready);
	modport sink (input valid, input operation, input value, input priority_req,
		output ready);
endinterface

interface tlpq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] front_value;
	logic [1:0]         front_priority;
	logic [4:0]         high_count;
	logic [4:0]         medium_count;
	logic [4:0]         low_count;
	logic               is_empty;
	logic [1:0]         status;

	modport source (output valid, output front_value, output front_priority,
		output high_count, output medium_count, output low_count, output is_empty,
		output status, input ready);
	modport sink (input valid, input front_value, input front_priority,
		input high_count, input medium_count, input low_count, input is_empty,
		input status, output ready);
endinterface

>>> hdl/tlpq_store.sv
// entry storage for all three level rings, one write and one registered read port
module tlpq_store (
	input  logic             clk,
	input  logic             re,
	input  tlpq_pkg::mem_req_t req,
	output tlpq_pkg::word_t  rdata
);

	tlpq_pkg::word_t mem_q [tlpq_pkg::MEM_DEPTH];
	tlpq_pkg::word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tlpq_ctrl.sv
// ring pointers, level counts and the per-word push/pop/peek decision
module tlpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  tlpq_pkg::item_t    item,
	output tlpq_pkg::mem_req_t mem_req,
	output tlpq_pkg::result_t  result
);

	tlpq_pkg::idx_t head_q [tlpq_pkg::NUM_LEVELS];
	tlpq_pkg::idx_t tail_q [tlpq_pkg::NUM_LEVELS];
	tlpq_pkg::cnt_t cnt_q  [tlpq_pkg::NUM_LEVELS];

	tlpq_pkg::idx_t head_n [tlpq_pkg::NUM_LEVELS];
	tlpq_pkg::idx_t tail_n [tlpq_pkg::NUM_LEVELS];
	tlpq_pkg::cnt_t cnt_n  [tlpq_pkg::NUM_LEVELS];

	logic [tlpq_pkg::NUM_LEVELS-1:0] push_hit;
	logic [tlpq_pkg::NUM_LEVELS-1:0] pop_hit;
	logic [tlpq_pkg::NUM_LEVELS-1:0] full_vec;
	logic [tlpq_pkg::NUM_LEVELS-1:0] busy_now;
	logic [tlpq_pkg::NUM_LEVELS-1:0] busy_next;
	tlpq_pkg::lvl_t   push_lvl;
	tlpq_pkg::lvl_t   top_now;
	tlpq_pkg::lvl_t   top_next;
	tlpq_pkg::idx_t   wr_idx;
	tlpq_pkg::idx_t   rd_idx;
	tlpq_pkg::status_t status;
	logic             push_ok;
	logic             pop_ok;
	tlpq_pkg::word_t  wdata;

	always_comb begin
		push_lvl = item.priority_req - 2'd1;
		for (int l = 0; l < tlpq_pkg::NUM_LEVELS; l++) begin
			busy_now[l] = (cnt_q[l] != '0);
			full_vec[l] = (cnt_q[l] == tlpq_pkg::CNT_W'(tlpq_pkg::LEVEL_DEPTH));
		end
		top_now = tlpq_pkg::top_level(busy_now);

		status = tlpq_pkg::ST_OK;
		push_ok = 1'b0;
		pop_ok = 1'b0;
		case (item.operation)
			tlpq_pkg::OP_PUSH: begin
				if (item.priority_req == tlpq_pkg::PRI_NONE) begin
					status = tlpq_pkg::ST_BADPRI;
				end else if (full_vec[push_lvl]) begin
					status = tlpq_pkg::ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			tlpq_pkg::OP_POP: begin
				if (top_now == tlpq_pkg::LVL_NONE) begin
					status = tlpq_pkg::ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			default: begin
				// peek, and the unused code, change nothing
			end
		endcase

		wr_idx = '0;
		for (int l = 0; l < tlpq_pkg::NUM_LEVELS; l++) begin
			push_hit[l] = push_ok && (push_lvl == tlpq_pkg::lvl_t'(l));
			pop_hit[l] = pop_ok && (top_now == tlpq_pkg::lvl_t'(l));
			head_n[l] = pop_hit[l] ? tlpq_pkg::ring_next(head_q[l]) : head_q[l];
			tail_n[l] = push_hit[l] ? tlpq_pkg::ring_next(tail_q[l]) : tail_q[l];
			cnt_n[l] = cnt_q[l];
			if (push_hit[l]) begin
				cnt_n[l] = cnt_q[l] + 1'b1;
				wr_idx = tail_q[l];
			end else if (pop_hit[l]) begin
				cnt_n[l] = cnt_q[l] - 1'b1;
			end
			busy_next[l] = (cnt_n[l] != '0);
		end
		top_next = tlpq_pkg::top_level(busy_next);

		rd_idx = '0;
		for (int l = 0; l < tlpq_pkg::NUM_LEVELS; l++) begin
			if (top_next == tlpq_pkg::lvl_t'(l)) begin
				rd_idx = head_n[l];
			end
		end
	end

	assign wdata = tlpq_pkg::VALUE_BITS'(item.value);

	always_comb begin
		mem_req.we = commit && push_ok;
		mem_req.waddr = tlpq_pkg::addr_of(push_lvl, wr_idx);
		mem_req.wdata = wdata;
		mem_req.raddr = (top_next == tlpq_pkg::LVL_NONE) ? '0 :
			tlpq_pkg::addr_of(top_next, rd_idx);

		result.front_priority = (top_next == tlpq_pkg::LVL_NONE) ? 2'd0 : top_next + 2'd1;
		result.high_count = 5'(cnt_n[0]);
		result.medium_count = 5'(cnt_n[1]);
		result.low_count = 5'(cnt_n[2]);
		result.is_empty = (top_next == tlpq_pkg::LVL_NONE);
		result.status = status;
		// pushed word is the new front in the same cycle the ram sees it
		result.bypass = push_ok && (mem_req.waddr == mem_req.raddr);
		result.bypass_value = wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < tlpq_pkg::NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l] <= '0;
			end
		end else if (commit) begin
			for (int l = 0; l < tlpq_pkg::NUM_LEVELS; l++) begin
				head_q[l] <= head_n[l];
				tail_q[l] <= tail_n[l];
				cnt_q[l] <= cnt_n[l];
			end
		end
	end

endmodule

>>> hdl/three_level_priority_queue.sv
// top level of the three-level priority queue
//
// three priority levels (1 high, 2 medium, 3 low), first in first out within
// a level, each level a ring of LEVEL_DEPTH entries in one shared ram
// req channel: one word per operation (push, pop front, peek); value and
// priority_req only matter for push
// rsp channel: exactly one word per request, in request order, giving the
// front value and level, the three level counts, the empty flag and status
// the response passes the input register, the state update with ram read and the
// output register after the request is accepted
// throughput: one word per cycle while rsp takes; the level pointers and counts
// are updated in a single registered pass, and the ram read of the new front overlaps it
// a push whose word becomes the front right away is forwarded around the ram
// reset clears the pointers and counts, so the queue comes up empty with no
// clearing pass; ram contents need no reset
// when rsp stalls the whole pipeline holds and req.ready drops with it;
// words already inside are kept and delivered once rsp takes again
module three_level_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	tlpq_req_if.sink          req,
	tlpq_rsp_if.source        rsp
);

	// pipeline advance: output register free or being taken
	logic adv;

	// input register
	logic            valid_s1;
	tlpq_pkg::item_t item_s1;

	// after state update, ram read in flight
	logic              valid_s2;
	tlpq_pkg::result_t res_s2;

	// output register
	logic               out_valid_q;
	logic signed [31:0] front_value_q;
	logic [1:0]         front_priority_q;
	logic [4:0]         high_count_q;
	logic [4:0]         medium_count_q;
	logic [4:0]         low_count_q;
	logic               is_empty_q;
	tlpq_pkg::status_t  status_q;

	tlpq_pkg::mem_req_t mem_req;
	tlpq_pkg::result_t  result;
	tlpq_pkg::word_t    rdata;
	tlpq_pkg::word_t    front_word;

	assign adv = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1.operation <= req.operation;
			item_s1.value <= req.value;
			item_s1.priority_req <= req.priority_req;
			res_s2 <= result;
		end
	end

	// state only moves when a real word sits in the input register
	tlpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (adv && valid_s1),
		.item    (item_s1),
		.mem_req (mem_req),
		.result  (result)
	);

	tlpq_store u_store (
		.clk   (clk),
		.re    (adv),
		.req   (mem_req),
		.rdata (rdata)
	);

	// front word: forwarded push data or ram data, zero when empty
	assign front_word = res_s2.bypass ? res_s2.bypass_value : rdata;

	always_ff @(posedge clk) begin
		if (adv) begin
			front_value_q <= res_s2.is_empty ? 32'sd0 : 32'(front_word);
			front_priority_q <= res_s2.front_priority;
			high_count_q <= res_s2.high_count;
			medium_count_q <= res_s2.medium_count;
			low_count_q <= res_s2.low_count;
			is_empty_q <= res_s2.is_empty;
			status_q <= res_s2.status;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.front_value = front_value_q;
	assign rsp.front_priority = front_priority_q;
	assign rsp.high_count = high_count_q;
	assign rsp.medium_count = medium_count_q;
	assign rsp.low_count = low_count_q;
	assign rsp.is_empty = is_empty_q;
	assign rsp.status = status_q;

`ifndef SYNTHESIS
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_empty |-> rsp.front_value == 32'sd0 && rsp.front_priority == 2'd0)
		else $error("empty queue reports a front entry");

	a_empty_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.is_empty == (rsp.high_count == 5'd0 && rsp.medium_count == 5'd0
			&& rsp.low_count == 5'd0))
		else $error("empty flag disagrees with level counts");

	a_front_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.front_priority == 2'd2 |-> rsp.high_count == 5'd0
			&& rsp.medium_count != 5'd0)
		else $error("medium front while high level holds entries");

	a_pipe_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 |=> out_valid_q)
		else $error("word lost between ram stage and output register");
`endif

endmodule

>>> tb/three_level_priority_queue_tb.sv
// self-checking testbench for the three-level priority queue: directed and random traffic on both channels
module three_level_priority_queue_tb;
	import tlpq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_WORDS = 1150;
	localparam int unsigned DRAIN_CYCLES = 20;

	// the op code with no name of its own, handled as a peek
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef enum {FILL_BURST, DRAIN_BURST, MIXED_BURST} burst_t;

	typedef struct {
		word_t      front_value;
		logic [1:0] front_priority;
		logic [4:0] high_count;
		logic [4:0] medium_count;
		logic [4:0] low_count;
		logic       is_empty;
		status_t    status;
	} queue_view_t;

	logic clk = 1'b0;
	logic arst_n;

	tlpq_req_if req_ch();
	tlpq_rsp_if rsp_ch();

	three_level_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	item_t       pending_words[$];
	queue_view_t expected_views[$];
	int unsigned accepted_count = 0;
	int unsigned total_words = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	// shadow of the queue: one ring per level
	word_t       lvl_store[NUM_LEVELS][LEVEL_DEPTH];
	int unsigned lvl_head[NUM_LEVELS];
	int unsigned lvl_tail[NUM_LEVELS];
	int unsigned lvl_fill[NUM_LEVELS];

	logic        send_calm, take_calm;
	int unsigned calm_left, send_gap, take_gap;

	function automatic int unsigned first_busy_level();
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (lvl_fill[l] != 0) begin
				return l;
			end
		end
		return NUM_LEVELS;
	endfunction

	// update the shadow queue with one operation and return the view after it
	function automatic queue_view_t apply_op(input item_t op_word);
		queue_view_t view;
		int unsigned lv;
		view.status = ST_OK;
		if (op_word.operation == OP_PUSH) begin
			if (op_word.priority_req == PRI_NONE) begin
				view.status = ST_BADPRI;
			end else begin
				lv = op_word.priority_req - 1;
				if (lvl_fill[lv] == LEVEL_DEPTH) begin
					view.status = ST_FULL;
				end else begin
					lvl_store[lv][lvl_tail[lv]] = op_word.value;
					lvl_tail[lv] = (lvl_tail[lv] + 1) % LEVEL_DEPTH;
					lvl_fill[lv] = lvl_fill[lv] + 1;
				end
			end
		end else if (op_word.operation == OP_POP) begin
			lv = first_busy_level();
			if (lv == NUM_LEVELS) begin
				view.status = ST_EMPTY;
			end else begin
				lvl_head[lv] = (lvl_head[lv] + 1) % LEVEL_DEPTH;
				lvl_fill[lv] = lvl_fill[lv] - 1;
			end
		end
		// peek and the spare code fall through with no change
		lv = first_busy_level();
		if (lv == NUM_LEVELS) begin
			view.front_value = '0;
			view.front_priority = PRI_NONE;
			view.is_empty = 1'b1;
		end else begin
			view.front_value = lvl_store[lv][lvl_head[lv]];
			view.front_priority = 2'(lv + 1);
			view.is_empty = 1'b0;
		end
		view.high_count = 5'(lvl_fill[0]);
		view.medium_count = 5'(lvl_fill[1]);
		view.low_count = 5'(lvl_fill[2]);
		return view;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap(input logic calm);
		int unsigned roll;
		roll = $urandom_range(99);
		if (calm || roll < 55) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 5);
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(19))
			0: return word_t'(32'h7fff_ffff);
			1: return word_t'(32'h8000_0000);
			2: return word_t'(32'h0000_0000);
			3: return word_t'(32'hffff_ffff);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic add_word(input logic [1:0] op, input word_t val, input logic [1:0] pri);
		item_t w;
		w.operation = op;
		w.value = val;
		w.priority_req = pri;
		pending_words.push_back(w);
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// switch each side between calm stretches and gappy stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_calm <= 1'b0;
			take_calm <= 1'b0;
			calm_left <= 0;
		end else if (calm_left == 0) begin
			send_calm <= ($urandom_range(3) == 0);
			take_calm <= ($urandom_range(3) == 0);
			calm_left <= $urandom_range(200, 20);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		item_t sent, next_word;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= OP_PEEK;
			req_ch.value <= '0;
			req_ch.priority_req <= PRI_NONE;
			send_gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				sent.operation = req_ch.operation;
				sent.value = req_ch.value;
				sent.priority_req = req_ch.priority_req;
				expected_views.push_back(apply_op(sent));
				accepted_count++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap != 0) begin
					req_ch.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= next_word.operation;
					req_ch.value <= next_word.value;
					req_ch.priority_req <= next_word.priority_req;
					send_gap <= pick_gap(send_calm);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		queue_view_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			take_gap <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_views.size() == 0) begin
					$display("%0t: response word with nothing outstanding, front 0x%0h status %0d",
						$time, rsp_ch.front_value, rsp_ch.status);
					fail_count++;
				end else begin
					want = expected_views.pop_front();
					check_field("front_value", want.front_value, rsp_ch.front_value);
					check_field("front_priority", 32'(want.front_priority),
						32'(rsp_ch.front_priority));
					check_field("high_count", 32'(want.high_count), 32'(rsp_ch.high_count));
					check_field("medium_count", 32'(want.medium_count),
						32'(rsp_ch.medium_count));
					check_field("low_count", 32'(want.low_count), 32'(rsp_ch.low_count));
					check_field("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
					check_field("status", 32'(want.status), 32'(rsp_ch.status));
				end
			end
			if (take_gap != 0) begin
				rsp_ch.ready <= 1'b0;
				take_gap <= take_gap - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
				take_gap <= pick_gap(take_calm);
			end
		end
	end

	initial begin
		burst_t      mode;
		int unsigned focus, burst_len, roll, made;
		logic [1:0]  op, pri;
		arst_n = 1'b0;

		// directed: empty-queue cases, bad priority, value extremes, level order
		add_word(OP_POP, word_t'(32'h1234_5678), 2'd1);
		add_word(OP_PEEK, '0, 2'd2);
		add_word(OP_SPARE, '0, 2'd3);
		add_word(OP_PUSH, word_t'(32'h0000_0007), PRI_NONE);
		add_word(OP_PUSH, word_t'(32'h7fff_ffff), 2'd3);
		add_word(OP_PUSH, word_t'(32'h8000_0000), 2'd2);
		add_word(OP_PEEK, word_t'(32'hffff_ffff), PRI_NONE);
		add_word(OP_PUSH, word_t'(32'hffff_ffff), 2'd1);
		add_word(OP_PUSH, word_t'(32'h0000_0000), 2'd1);
		add_word(OP_SPARE, word_t'(32'h5555_5555), 2'd1);
		add_word(OP_PUSH, word_t'(32'haaaa_aaaa), PRI_NONE);
		add_word(OP_POP, '0, PRI_NONE);
		add_word(OP_POP, '0, 2'd3);
		add_word(OP_POP, '0, 2'd2);
		add_word(OP_PEEK, '0, 2'd1);
		add_word(OP_POP, '0, 2'd1);
		add_word(OP_POP, '0, PRI_NONE);
		add_word(OP_PEEK, '0, PRI_NONE);

		// random bursts: fill bursts push hard on one level to drive it toward overflow,
		// drain bursts mostly pop to run the queue down, mixed bursts wander in between
		made = 0;
		while (made < RANDOM_WORDS) begin
			mode = burst_t'($urandom_range(2));
			focus = $urandom_range(3, 1);
			burst_len = $urandom_range(60, 10);
			for (int i = 0; i < burst_len; i++) begin
				roll = $urandom_range(99);
				case (mode)
					FILL_BURST:
						op = (roll < 85) ? OP_PUSH : (roll < 93) ? OP_POP :
							(roll < 97) ? OP_PEEK : OP_SPARE;
					DRAIN_BURST:
						op = (roll < 15) ? OP_PUSH : (roll < 90) ? OP_POP :
							(roll < 96) ? OP_PEEK : OP_SPARE;
					default:
						op = (roll < 45) ? OP_PUSH : (roll < 85) ? OP_POP :
							(roll < 95) ? OP_PEEK : OP_SPARE;
				endcase
				roll = $urandom_range(99);
				pri = (roll < 5) ? PRI_NONE : (roll < 70) ? 2'(focus) :
					2'($urandom_range(3, 1));
				add_word(op, rand_word(), pri);
			end
			made += burst_len;
		end
		total_words = pending_words.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_words || expected_views.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("three_level_priority_queue_tb OK");
		end else begin
			$display("three_level_priority_queue_tb NOT OK");
		end
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d words accepted and %0d responses outstanding",
			$time, accepted_count, expected_views.size());
		$display("three_level_priority_queue_tb NOT OK");
		$finish;
	end

endmodule
